FILE: sv/pdo_pkg.sv
package pdo_pkg;

  localparam int POSITION_BITS_DEF = 48;
  localparam int TRIG_BITS_DEF     = 16;

  localparam int VEL_W   = 16;
  localparam int DT_W    = 20;
  localparam int POS_W   = 48;
  localparam int POS_MAX = 64;
  localparam int ANG_W   = 33;
  localparam int HW      = 37;
  localparam int CX_W    = 34;
  localparam int Q15_W   = 16;
  localparam int RX_W    = 33;
  localparam int MA_W    = 34;
  localparam int MB_W    = 21;
  localparam int MP_W    = 55;
  localparam int ATAN_IW = 5;

  localparam logic signed [ANG_W-1:0] PI_NRAD          = 33'sd3141592654;
  localparam logic signed [ANG_W-1:0] NEG_PI_NRAD      = -33'sd3141592654;
  localparam logic signed [ANG_W-1:0] HALF_PI_NRAD     = 33'sd1570796327;
  localparam logic signed [ANG_W-1:0] NEG_HALF_PI_NRAD = -33'sd1570796327;
  localparam logic signed [CX_W-1:0]  CORDIC_GAIN_Q30  = 34'sd652032874;

  localparam logic signed [HW-1:0] PI_H       = 37'sd3141592654;
  localparam logic signed [HW-1:0] NEG_PI_H   = -37'sd3141592654;
  localparam logic signed [HW-1:0] PERIOD_X8  = 37'sd50265482464;
  localparam logic signed [HW-1:0] NEG_PER_X4 = -37'sd25132741232;
  localparam logic signed [HW-1:0] NEG_PER_X2 = -37'sd12566370616;
  localparam logic signed [HW-1:0] NEG_PER_X1 = -37'sd6283185308;

  localparam logic signed [CX_W:0]   Q15_RND  = 35'sd16384;
  localparam logic signed [CX_W:0]   Q15_HI   = 35'sd32767;
  localparam logic signed [CX_W:0]   Q15_LO   = -35'sd32768;
  localparam logic signed [MP_W-1:0] PROD_RND = 55'sd16384;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIG,
    ST_MUL,
    ST_WRAP,
    ST_QUAT,
    ST_DONE
  } pdo_state_t;

  // named by the product issued in that step
  typedef enum logic [2:0] {
    MS_VXC,
    MS_VYS,
    MS_VXS,
    MS_VYC,
    MS_RXT,
    MS_RYT,
    MS_WZT,
    MS_HEAD
  } pdo_mul_step_t;

  typedef enum logic [2:0] {
    WS_NEG,
    WS_SUB4,
    WS_SUB2,
    WS_SUB1,
    WS_CENTRE
  } pdo_wrap_step_t;

  typedef struct packed {
    logic                    start;
    logic signed [ANG_W-1:0] angle;
  } pdo_trig_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [Q15_W-1:0] sin;
    logic signed [Q15_W-1:0] cos;
  } pdo_trig_res_t;

  function automatic logic signed [ANG_W-1:0] atan_nrad(input logic [ATAN_IW-1:0] idx);
    case (idx)
      5'd0:    atan_nrad = 33'sd785398163;
      5'd1:    atan_nrad = 33'sd463647609;
      5'd2:    atan_nrad = 33'sd244978663;
      5'd3:    atan_nrad = 33'sd124354995;
      5'd4:    atan_nrad = 33'sd62418810;
      5'd5:    atan_nrad = 33'sd31239833;
      5'd6:    atan_nrad = 33'sd15623729;
      5'd7:    atan_nrad = 33'sd7812341;
      5'd8:    atan_nrad = 33'sd3906230;
      5'd9:    atan_nrad = 33'sd1953123;
      5'd10:   atan_nrad = 33'sd976562;
      5'd11:   atan_nrad = 33'sd488281;
      5'd12:   atan_nrad = 33'sd244141;
      5'd13:   atan_nrad = 33'sd122070;
      5'd14:   atan_nrad = 33'sd61035;
      5'd15:   atan_nrad = 33'sd30518;
      5'd16:   atan_nrad = 33'sd15259;
      5'd17:   atan_nrad = 33'sd7629;
      5'd18:   atan_nrad = 33'sd3815;
      5'd19:   atan_nrad = 33'sd1907;
      5'd20:   atan_nrad = 33'sd954;
      5'd21:   atan_nrad = 33'sd477;
      5'd22:   atan_nrad = 33'sd238;
      5'd23:   atan_nrad = 33'sd119;
      default: atan_nrad = '0;
    endcase
  endfunction

  // q30 to q1.15, round half up, saturating
  function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [CX_W:0] v);
    logic signed [CX_W:0] r;
    r = (v + Q15_RND) >>> 15;
    if (r > Q15_HI) begin
      r = Q15_HI;
    end else if (r < Q15_LO) begin
      r = Q15_LO;
    end
    to_q15 = r[Q15_W-1:0];
  endfunction

endpackage

FILE: sv/pdo_mul.sv
module pdo_mul (
  input  logic                            clk,
  input  logic signed [pdo_pkg::MA_W-1:0] mul_a,
  input  logic signed [pdo_pkg::MB_W-1:0] mul_b,
  output logic signed [pdo_pkg::MP_W-1:0] mul_p
);
  import pdo_pkg::*;

  logic signed [MP_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= MP_W'(mul_a) * MP_W'(mul_b);
  end

  assign mul_p = prod_r;

endmodule

FILE: sv/pdo_cordic.sv
module pdo_cordic #(
  parameter int TRIG_BITS = pdo_pkg::TRIG_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pdo_pkg::pdo_trig_req_t trig_req,
  output pdo_pkg::pdo_trig_res_t trig_res
);
  import pdo_pkg::*;

  localparam int CW = $clog2(TRIG_BITS);
  localparam logic [CW-1:0] LAST = CW'(TRIG_BITS - 1);

  logic                    busy_r, busy_nxt;
  logic                    round_r, round_nxt;
  logic                    done_r;
  logic                    flip_r, flip_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic signed [CX_W-1:0]  x_r, x_nxt, y_r, y_nxt, x_sh, y_sh;
  logic signed [ANG_W-1:0] z_r, z_nxt, ang, step_ang;
  logic signed [CX_W:0]    x_fin, y_fin;
  logic signed [Q15_W-1:0] sin_r, cos_r;

  always_comb begin
    ang      = $signed(trig_req.angle);
    x_sh     = x_r >>> cnt_r;
    y_sh     = y_r >>> cnt_r;
    step_ang = atan_nrad(ATAN_IW'(cnt_r));
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    flip_nxt = flip_r;
    priority if (trig_req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      x_nxt    = CORDIC_GAIN_Q30;
      y_nxt    = '0;
      // fold into the right half plane, negate both outputs at the end
      if (ang > HALF_PI_NRAD) begin
        z_nxt    = ang - PI_NRAD;
        flip_nxt = 1'b1;
      end else if (ang < NEG_HALF_PI_NRAD) begin
        z_nxt    = ang + PI_NRAD;
        flip_nxt = 1'b1;
      end else begin
        z_nxt    = ang;
        flip_nxt = 1'b0;
      end
    end else if (busy_r) begin
      if (!z_r[ANG_W-1]) begin
        x_nxt = x_r - y_sh;
        y_nxt = y_r + x_sh;
        z_nxt = z_r - step_ang;
      end else begin
        x_nxt = x_r + y_sh;
        y_nxt = y_r - x_sh;
        z_nxt = z_r + step_ang;
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
      end
    end else begin
      busy_nxt = 1'b0;
    end
    round_nxt = busy_r && (cnt_r == LAST) && !trig_req.start;
    x_fin = flip_r ? -(CX_W+1)'(x_r) : (CX_W+1)'(x_r);
    y_fin = flip_r ? -(CX_W+1)'(y_r) : (CX_W+1)'(y_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      round_r <= 1'b0;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      round_r <= round_nxt;
      done_r  <= round_r;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    flip_r <= flip_nxt;
    if (round_r) begin
      sin_r <= to_q15(y_fin);
      cos_r <= to_q15(x_fin);
    end
  end

  always_comb begin
    trig_res.done = done_r;
    trig_res.sin  = sin_r;
    trig_res.cos  = cos_r;
  end

`ifndef SYNTHESIS
  a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    trig_req.start |-> (!busy_r && !round_r))
    else $error("cordic started while a rotation is in progress");

  a_done_after_round: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(round_r))
    else $error("cordic done without a finishing round");
`endif

endmodule

FILE: sv/planar_odometry_integrator.sv
// Planar dead-reckoning odometry. Each accepted input word carries body-frame forward and
// lateral velocity (mm/s), yaw rate (mrad/s) and elapsed time (us). A word with zero elapsed
// time is taken and changes nothing. Any other word rotates the velocity by the
// stored heading (CORDIC sine and cosine, Q1.15), scales it by the elapsed time into wrapping
// nanometre x and y, advances the heading in nanoradians wrapped to [-pi, pi) and returns one
// result word with the pose, the yaw quaternion z and w (w never negative) and the velocities
// of the word. Input is held off while a word is in work; the finished result sits in an
// output register, so the next word is taken while the result waits. Each word makes two
// passes through the shared CORDIC, seven products through the shared 34x21 multiplier and
// a five-step heading wrap. Position and heading clear at reset.
module planar_odometry_integrator #(
  parameter int POSITION_BITS = pdo_pkg::POSITION_BITS_DEF,
  parameter int TRIG_BITS     = pdo_pkg::TRIG_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [pdo_pkg::VEL_W-1:0] in_forward_velocity,
  input  logic signed [pdo_pkg::VEL_W-1:0] in_lateral_velocity,
  input  logic signed [pdo_pkg::VEL_W-1:0] in_yaw_rate,
  input  logic        [pdo_pkg::DT_W-1:0]  in_elapsed_us,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [pdo_pkg::POS_W-1:0] out_x_position_nm,
  output logic signed [pdo_pkg::POS_W-1:0] out_y_position_nm,
  output logic signed [pdo_pkg::ANG_W-1:0] out_heading_nrad,
  output logic signed [pdo_pkg::Q15_W-1:0] out_quat_z,
  output logic        [pdo_pkg::Q15_W-2:0] out_quat_w,
  output logic signed [pdo_pkg::VEL_W-1:0] out_echo_forward,
  output logic signed [pdo_pkg::VEL_W-1:0] out_echo_lateral,
  output logic signed [pdo_pkg::VEL_W-1:0] out_echo_yaw_rate
);
  import pdo_pkg::*;

  pdo_state_t     state_r, state_nxt;
  pdo_mul_step_t  mstep_r;
  pdo_wrap_step_t wstep_r;
  pdo_trig_req_t  trig_req;
  pdo_trig_res_t  trig_res;

  logic                     item_go, out_load, out_valid_r, wrap_take;
  logic signed [VEL_W-1:0]  vx_r, vy_r, wz_r;
  logic        [DT_W-1:0]   dt_r;
  logic signed [RX_W-1:0]   rx_r, ry_r, prod_lo;
  logic [POSITION_BITS-1:0] pos_x_r, pos_y_r;
  logic signed [ANG_W-1:0]  heading_r, wrap_head;
  logic signed [HW-1:0]     hacc_r, wrap_k, wrap_sum;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [MP_W-1:0]   prod, prod_rnd;
  logic signed [POS_MAX-1:0] delta;
  logic [POS_MAX-1:0]       px_w, py_w;

  logic signed [POS_W-1:0]   x_out_r, y_out_r;
  logic signed [ANG_W-1:0]   head_out_r;
  logic signed [Q15_W-1:0]   qz_out_r;
  logic        [Q15_W-2:0]   qw_out_r;
  logic signed [VEL_W-1:0]   ef_out_r, el_out_r, ey_out_r;

  pdo_cordic #(
    .TRIG_BITS (TRIG_BITS)
  ) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .trig_req (trig_req),
    .trig_res (trig_res)
  );

  pdo_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (prod)
  );

  assign item_go = (state_r == ST_IDLE) && in_valid && (in_elapsed_us != '0);

  // heading wrap, one add per step
  always_comb begin
    unique case (wstep_r)
      WS_NEG:    wrap_k = PERIOD_X8;
      WS_SUB4:   wrap_k = NEG_PER_X4;
      WS_SUB2:   wrap_k = NEG_PER_X2;
      WS_SUB1:   wrap_k = NEG_PER_X1;
      WS_CENTRE: wrap_k = NEG_PI_H;
      default:   wrap_k = '0;
    endcase
    wrap_sum  = hacc_r + wrap_k;
    wrap_head = $signed(wrap_sum[ANG_W-1:0]);
    priority if (wstep_r == WS_NEG) begin
      wrap_take = hacc_r[HW-1];
    end else if (wstep_r == WS_CENTRE) begin
      wrap_take = 1'b1;
    end else begin
      wrap_take = !wrap_sum[HW-1];
    end
  end

  // multiplier operands
  always_comb begin
    unique case (mstep_r)
      MS_VXC: begin
        mul_a = MA_W'(vx_r);
        mul_b = MB_W'($signed(trig_res.cos));
      end
      MS_VYS: begin
        mul_a = MA_W'(vy_r);
        mul_b = MB_W'($signed(trig_res.sin));
      end
      MS_VXS: begin
        mul_a = MA_W'(vx_r);
        mul_b = MB_W'($signed(trig_res.sin));
      end
      MS_VYC: begin
        mul_a = MA_W'(vy_r);
        mul_b = MB_W'($signed(trig_res.cos));
      end
      MS_RXT: begin
        mul_a = MA_W'(rx_r);
        mul_b = {1'b0, dt_r};
      end
      MS_RYT: begin
        mul_a = MA_W'(ry_r);
        mul_b = {1'b0, dt_r};
      end
      MS_WZT, MS_HEAD: begin
        mul_a = MA_W'(wz_r);
        mul_b = {1'b0, dt_r};
      end
    endcase
    prod_lo  = $signed(prod[RX_W-1:0]);
    prod_rnd = prod + PROD_RND;
    delta    = POS_MAX'(prod_rnd >>> 15);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (item_go) begin
        state_nxt = ST_TRIG;
      end
      ST_TRIG: if (trig_res.done) begin
        state_nxt = ST_MUL;
      end
      ST_MUL: if (mstep_r == MS_HEAD) begin
        state_nxt = ST_WRAP;
      end
      ST_WRAP: if (wstep_r == WS_CENTRE) begin
        state_nxt = ST_QUAT;
      end
      ST_QUAT: if (trig_res.done) begin
        state_nxt = ST_DONE;
      end
      ST_DONE: if (!out_valid_r || !out_stall) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall       = 1'b1;
    out_load       = 1'b0;
    trig_req.start = 1'b0;
    trig_req.angle = heading_r;
    unique case (state_r)
      ST_IDLE: begin
        in_stall       = 1'b0;
        trig_req.start = item_go;
      end
      ST_WRAP: begin
        trig_req.start = (wstep_r == WS_CENTRE);
        trig_req.angle = wrap_head >>> 1;
      end
      ST_DONE: out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mstep_r     <= MS_VXC;
      wstep_r     <= WS_NEG;
      out_valid_r <= 1'b0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      heading_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_TRIG) begin
        mstep_r <= MS_VXC;
      end else if (state_r == ST_MUL) begin
        mstep_r <= pdo_mul_step_t'(mstep_r + 3'd1);
        if (mstep_r == MS_RYT) begin
          pos_x_r <= pos_x_r + delta[POSITION_BITS-1:0];
        end
        if (mstep_r == MS_WZT) begin
          pos_y_r <= pos_y_r + delta[POSITION_BITS-1:0];
        end
      end
      if (state_r == ST_MUL) begin
        wstep_r <= WS_NEG;
      end else if (state_r == ST_WRAP) begin
        wstep_r <= pdo_wrap_step_t'(wstep_r + 3'd1);
        if (wstep_r == WS_CENTRE) begin
          heading_r <= wrap_head;
        end
      end
    end
  end

  // item and product registers
  always_ff @(posedge clk) begin
    if (item_go) begin
      vx_r <= in_forward_velocity;
      vy_r <= in_lateral_velocity;
      wz_r <= in_yaw_rate;
      dt_r <= in_elapsed_us;
    end
    if (state_r == ST_MUL) begin
      unique case (mstep_r)
        MS_VYS:  rx_r <= prod_lo;
        MS_VXS:  rx_r <= rx_r - prod_lo;
        MS_VYC:  ry_r <= prod_lo;
        MS_RXT:  ry_r <= ry_r + prod_lo;
        MS_HEAD: hacc_r <= HW'(heading_r) + $signed(prod[HW-1:0]) + PI_H;
        default: ;
      endcase
    end else if (state_r == ST_WRAP && wrap_take) begin
      hacc_r <= wrap_sum;
    end
  end

  assign px_w = POS_MAX'(pos_x_r);
  assign py_w = POS_MAX'(pos_y_r);

  // result word register
  always_ff @(posedge clk) begin
    if (out_load) begin
      x_out_r    <= $signed(px_w[POS_W-1:0]);
      y_out_r    <= $signed(py_w[POS_W-1:0]);
      head_out_r <= heading_r;
      qz_out_r   <= trig_res.sin;
      qw_out_r   <= trig_res.cos[Q15_W-1] ? '0 : trig_res.cos[Q15_W-2:0];
      ef_out_r   <= vx_r;
      el_out_r   <= vy_r;
      ey_out_r   <= wz_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_x_position_nm = x_out_r;
  assign out_y_position_nm = y_out_r;
  assign out_heading_nrad  = head_out_r;
  assign out_quat_z        = qz_out_r;
  assign out_quat_w        = qw_out_r;
  assign out_echo_forward  = ef_out_r;
  assign out_echo_lateral  = el_out_r;
  assign out_echo_yaw_rate = ey_out_r;

`ifndef SYNTHESIS
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    (heading_r >= NEG_PI_NRAD) && (heading_r < PI_NRAD))
    else $error("heading outside minus pi to pi");

  a_skip_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid && in_elapsed_us == '0) |=> (state_r == ST_IDLE))
    else $error("zero elapsed time word started work");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result word raised outside the finishing state");
`endif

endmodule
